// File: src/single_wire_humidity_sensor_reader_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the single-wire humidity sensor reader
// Clocked, reset-qualified implication forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef SINGLE_WIRE_HUMIDITY_SENSOR_READER_UNIT_ASSERT_SVH
`define SINGLE_WIRE_HUMIDITY_SENSOR_READER_UNIT_ASSERT_SVH

// same-cycle implication
`define SWHS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication violated");

// next-cycle implication
`define SWHS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication violated");

`endif

// File: src/swhs_pkg.sv
// ----------------------------------------------------------------------------
// swhs_pkg
// Codes, widths and reset values of the single-wire humidity sensor reader.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package swhs_pkg;

   localparam int TIMER_WIDTH = 16;
   localparam int BIT_WIDTH   = 6;
   localparam int FRAME_WIDTH = 40;
   localparam int CSR_WIDTH   = 16;
   localparam int CSR_INDEX_WIDTH = 2;

   localparam logic [BIT_WIDTH-1:0] FRAME_BITS = 6'd40;

   // register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_START_LOW     = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RELEASE       = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TIMEOUT       = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ONE_THRESHOLD = 2'd3;

   localparam logic [15:0] START_LOW_RESET     = 16'd20000;
   localparam logic [7:0]  RELEASE_RESET       = 8'd30;
   localparam logic [15:0] TIMEOUT_RESET       = 16'd1000;
   localparam logic [7:0]  ONE_THRESHOLD_RESET = 8'd40;

   // drive modes
   localparam logic [1:0] DRIVE_RELEASED = 2'd0;
   localparam logic [1:0] DRIVE_LOW      = 2'd1;
   localparam logic [1:0] DRIVE_HIGH     = 2'd2;

   // status codes
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_TIMEOUT  = 2'd1;
   localparam logic [1:0] STATUS_CHECKSUM = 2'd2;

   // failing stages
   localparam logic [2:0] STAGE_NONE       = 3'd0;
   localparam logic [2:0] STAGE_RESP_LOW   = 3'd1;
   localparam logic [2:0] STAGE_RESP_HIGH  = 3'd2;
   localparam logic [2:0] STAGE_RESP_LOW2  = 3'd3;
   localparam logic [2:0] STAGE_BIT_RISE   = 3'd4;
   localparam logic [2:0] STAGE_BIT_FALL   = 3'd5;

   typedef struct packed {
      logic [1:0]           drive_mode;
      logic                 busy_res;
      logic                 done_res;
      logic [1:0]           status;
      logic [2:0]           fault_stage;
      logic [BIT_WIDTH-1:0] fault_bit;
      logic [7:0]           humidity;
      logic [7:0]           temperature;
   } rsp_type;

endpackage

// File: src/swhs_if.sv
// ----------------------------------------------------------------------------
// swhs_req_if / swhs_rsp_if
// Valid/ready channels for tick requests and per-tick results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface swhs_req_if;
   logic valid;
   logic ready;
   logic start_request;
   logic line_level;

   modport source (output valid, output start_request, output line_level, input ready);
   modport sink   (input valid, input start_request, input line_level, output ready);
endinterface

interface swhs_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] drive_mode;
   logic       busy_res;
   logic       done_res;
   logic [1:0] status;
   logic [2:0] fault_stage;
   logic [5:0] fault_bit;
   logic [7:0] humidity;
   logic [7:0] temperature;

   modport source (output valid, output drive_mode, output busy_res, output done_res,
                   output status, output fault_stage, output fault_bit, output humidity,
                   output temperature, input ready);
   modport sink   (input valid, input drive_mode, input busy_res, input done_res,
                   input status, input fault_stage, input fault_bit, input humidity,
                   input temperature, output ready);
endinterface

// File: src/single_wire_humidity_sensor_reader_unit.sv
// ----------------------------------------------------------------------------
// single_wire_humidity_sensor_reader_unit
// Each request is one microsecond tick with a start flag and the sampled
// data-line level; every request produces exactly one response in the next
// cycle, carrying the line drive, busy/done flags, last status and the last
// good humidity and temperature bytes. A request is taken every cycle while
// the response register is empty or being drained; the sequencer state and
// the response register update together on the same edge, so throughput is
// one request per cycle under that condition. The user must write registers
// through the csr port only while no read is in progress (not enforced).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module single_wire_humidity_sensor_reader_unit (
   input  logic                                    clock,
   input  logic                                    reset,
   swhs_req_if.sink                                req_chan,
   swhs_rsp_if.source                              rsp_chan,
   input  logic                                    csr_write_enable,
   input  logic [swhs_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [swhs_pkg::CSR_WIDTH-1:0]          csr_write_data
);
   import swhs_pkg::*;

   localparam logic [2:0] PH_IDLE      = 3'd0;
   localparam logic [2:0] PH_START_LOW = 3'd1;
   localparam logic [2:0] PH_RELEASE   = 3'd2;
   localparam logic [2:0] PH_RESP_LOW  = 3'd3;
   localparam logic [2:0] PH_RESP_HIGH = 3'd4;
   localparam logic [2:0] PH_RESP_LOW2 = 3'd5;
   localparam logic [2:0] PH_BIT_RISE  = 3'd6;
   localparam logic [2:0] PH_BIT_FALL  = 3'd7;

   logic [15:0] start_low_ff, timeout_ff;
   logic [7:0]  release_ff, threshold_ff;

   logic [2:0]             phase_ff, phase_in;
   logic [TIMER_WIDTH-1:0] timer_ff, timer_in;
   logic [BIT_WIDTH-1:0]   bit_index_ff, bit_index_in;
   logic [FRAME_WIDTH-1:0] frame_ff, frame_in;
   logic [7:0]             humidity_ff, humidity_in, temperature_ff, temperature_in;
   logic [1:0]             status_ff, status_in;
   logic [2:0]             stage_ff, stage_in;
   logic [BIT_WIDTH-1:0]   bit_hold_ff, bit_hold_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;

   logic       accept;
   logic       done;
   logic       miss;
   logic [2:0] miss_stage;
   logic       one_bit;
   logic [7:0] checksum;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept = req_chan.valid && req_chan.ready;

   assign one_bit  = timer_ff >= {8'd0, threshold_ff};
   assign checksum = frame_ff[38:31] + frame_ff[30:23] + frame_ff[22:15] + frame_ff[14:7];

   always_comb begin
      phase_in       = phase_ff;
      timer_in       = timer_ff;
      bit_index_in   = bit_index_ff;
      frame_in       = frame_ff;
      humidity_in    = humidity_ff;
      temperature_in = temperature_ff;
      status_in      = status_ff;
      stage_in       = stage_ff;
      bit_hold_in    = bit_hold_ff;
      done           = 1'b0;
      miss           = 1'b0;
      miss_stage     = STAGE_NONE;
      case (phase_ff)
         PH_IDLE: begin
            if (req_chan.start_request) begin
               phase_in     = PH_START_LOW;
               timer_in     = 16'd1;
               bit_index_in = '0;
               frame_in     = '0;
            end
         end
         PH_START_LOW: begin
            if (timer_ff >= start_low_ff) begin
               phase_in = PH_RELEASE;
               timer_in = 16'd1;
            end else begin
               timer_in = timer_ff + 16'd1;
            end
         end
         PH_RELEASE: begin
            if (timer_ff >= {8'd0, release_ff}) begin
               phase_in = PH_RESP_LOW;
               timer_in = '0;
            end else begin
               timer_in = timer_ff + 16'd1;
            end
         end
         PH_RESP_LOW: begin
            if (!req_chan.line_level) begin
               phase_in = PH_RESP_HIGH;
               timer_in = '0;
            end else begin
               miss       = 1'b1;
               miss_stage = STAGE_RESP_LOW;
            end
         end
         PH_RESP_HIGH: begin
            if (req_chan.line_level) begin
               phase_in = PH_RESP_LOW2;
               timer_in = '0;
            end else begin
               miss       = 1'b1;
               miss_stage = STAGE_RESP_HIGH;
            end
         end
         PH_RESP_LOW2: begin
            if (!req_chan.line_level) begin
               phase_in = PH_BIT_RISE;
               timer_in = '0;
            end else begin
               miss       = 1'b1;
               miss_stage = STAGE_RESP_LOW2;
            end
         end
         PH_BIT_RISE: begin
            if (req_chan.line_level) begin
               phase_in = PH_BIT_FALL;
               timer_in = '0;
            end else begin
               miss       = 1'b1;
               miss_stage = STAGE_BIT_RISE;
            end
         end
         default: begin
            if (!req_chan.line_level) begin
               frame_in     = {frame_ff[FRAME_WIDTH-2:0], one_bit};
               bit_index_in = bit_index_ff + 6'd1;
               timer_in     = '0;
               if (bit_index_in >= FRAME_BITS) begin
                  done        = 1'b1;
                  phase_in    = PH_IDLE;
                  stage_in    = STAGE_NONE;
                  bit_hold_in = '0;
                  if (checksum == frame_in[7:0]) begin
                     humidity_in    = frame_in[39:32];
                     temperature_in = frame_in[23:16];
                     status_in      = STATUS_OK;
                  end else begin
                     status_in = STATUS_CHECKSUM;
                  end
               end else begin
                  phase_in = PH_BIT_RISE;
               end
            end else begin
               miss       = 1'b1;
               miss_stage = STAGE_BIT_FALL;
            end
         end
      endcase
      if (miss) begin
         if (timer_ff >= timeout_ff) begin
            done        = 1'b1;
            phase_in    = PH_IDLE;
            timer_in    = '0;
            status_in   = STATUS_TIMEOUT;
            stage_in    = miss_stage;
            bit_hold_in = (miss_stage >= STAGE_BIT_RISE) ? bit_index_ff : '0;
         end else begin
            timer_in = timer_ff + 16'd1;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_in       = rsp_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         case (phase_in)
            PH_START_LOW: rsp_in.drive_mode = DRIVE_LOW;
            PH_RELEASE:   rsp_in.drive_mode = DRIVE_HIGH;
            default:      rsp_in.drive_mode = DRIVE_RELEASED;
         endcase
         rsp_in.busy_res    = phase_in != PH_IDLE;
         rsp_in.done_res    = done;
         rsp_in.status      = status_in;
         rsp_in.fault_stage = stage_in;
         rsp_in.fault_bit   = bit_hold_in;
         rsp_in.humidity    = humidity_in;
         rsp_in.temperature = temperature_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_low_ff   <= START_LOW_RESET;
         release_ff     <= RELEASE_RESET;
         timeout_ff     <= TIMEOUT_RESET;
         threshold_ff   <= ONE_THRESHOLD_RESET;
         phase_ff       <= PH_IDLE;
         timer_ff       <= '0;
         bit_index_ff   <= '0;
         frame_ff       <= '0;
         humidity_ff    <= '0;
         temperature_ff <= '0;
         status_ff      <= STATUS_OK;
         stage_ff       <= STAGE_NONE;
         bit_hold_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_START_LOW:     start_low_ff <= csr_write_data;
               CSR_RELEASE:       release_ff   <= csr_write_data[7:0];
               CSR_TIMEOUT:       timeout_ff   <= csr_write_data;
               CSR_ONE_THRESHOLD: threshold_ff <= csr_write_data[7:0];
               default:           threshold_ff <= threshold_ff;
            endcase
         end
         if (accept) begin
            phase_ff       <= phase_in;
            timer_ff       <= timer_in;
            bit_index_ff   <= bit_index_in;
            frame_ff       <= frame_in;
            humidity_ff    <= humidity_in;
            temperature_ff <= temperature_in;
            status_ff      <= status_in;
            stage_ff       <= stage_in;
            bit_hold_ff    <= bit_hold_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.drive_mode  = rsp_ff.drive_mode;
   assign rsp_chan.busy_res    = rsp_ff.busy_res;
   assign rsp_chan.done_res    = rsp_ff.done_res;
   assign rsp_chan.status      = rsp_ff.status;
   assign rsp_chan.fault_stage = rsp_ff.fault_stage;
   assign rsp_chan.fault_bit   = rsp_ff.fault_bit;
   assign rsp_chan.humidity    = rsp_ff.humidity;
   assign rsp_chan.temperature = rsp_ff.temperature;

endmodule

// File: src/swhs_checker.sv
// ----------------------------------------------------------------------------
// swhs_checker
// Port-level checks of the sensor reader, bound to its top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module swhs_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_drive_mode,
   input logic       rsp_busy_res,
   input logic       rsp_done_res,
   input logic [1:0] rsp_status,
   input logic [2:0] rsp_fault_stage
);
   import swhs_pkg::*;

`include "single_wire_humidity_sensor_reader_unit_assert.svh"

   `SWHS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_drive_mode) && $stable(rsp_status))
   `SWHS_ASSERT_NEXT(a_req_to_rsp, clock, reset, req_valid && req_ready, rsp_valid)
   `SWHS_ASSERT_IMPLY(a_done_idle, clock, reset, rsp_valid && rsp_done_res, !rsp_busy_res && rsp_drive_mode == DRIVE_RELEASED)
   `SWHS_ASSERT_IMPLY(a_drive_busy, clock, reset, rsp_valid && rsp_drive_mode != DRIVE_RELEASED, rsp_busy_res)
   `SWHS_ASSERT_IMPLY(a_timeout_stage, clock, reset, rsp_valid && rsp_status == STATUS_TIMEOUT, rsp_fault_stage != STAGE_NONE)

endmodule

bind single_wire_humidity_sensor_reader_unit swhs_checker u_swhs_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_drive_mode  (rsp_chan.drive_mode),
   .rsp_busy_res    (rsp_chan.busy_res),
   .rsp_done_res    (rsp_chan.done_res),
   .rsp_status      (rsp_chan.status),
   .rsp_fault_stage (rsp_chan.fault_stage)
);
